@@ rtl/irsfd_pkg.sv @@
// Shared types, register indexes and code constants for the sampled IR frame decoder.
// Used by the CSR channel interface, the decode module and the top level.
`timescale 1ns / 1ps
package irsfd_pkg;

   // Number of samples that make up one frame by default.
   localparam int FRAME_SAMPLES_DEF = 58;
   // Samples 0 to 51 carry the decoded fields.
   localparam int DECODE_SAMPLES = 52;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LEADER     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_START      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_FRAME_MODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOGGLE_VALUE_A      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOGGLE_VALUE_B      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ADDRESS    = 3'd5;

   localparam logic [2:0] STATUS_NEW_KEY     = 3'd0;
   localparam logic [2:0] STATUS_BAD_LEADER  = 3'd1;
   localparam logic [2:0] STATUS_BAD_START   = 3'd2;
   localparam logic [2:0] STATUS_BAD_MODE    = 3'd3;
   localparam logic [2:0] STATUS_BAD_TOGGLE  = 3'd4;
   localparam logic [2:0] STATUS_BAD_ADDRESS = 3'd5;
   localparam logic [2:0] STATUS_REPEAT      = 3'd6;

   localparam logic [2:0] CLASS_DIGIT        = 3'd0;
   localparam logic [2:0] CLASS_TOTAL_ONE    = 3'd1;
   localparam logic [2:0] CLASS_TOTAL_TWO    = 3'd2;
   localparam logic [2:0] CLASS_MENU         = 3'd3;
   localparam logic [2:0] CLASS_CLEAR_TOTALS = 3'd4;
   localparam logic [2:0] CLASS_OTHER        = 3'd5;

   localparam logic [7:0] CMD_DIGIT_MAX    = 8'h09;
   localparam logic [7:0] CMD_TOTAL_ONE    = 8'h0f;
   localparam logic [7:0] CMD_TOTAL_TWO    = 8'h4e;
   localparam logic [7:0] CMD_MENU         = 8'hd1;
   localparam logic [7:0] CMD_CLEAR_TOTALS = 8'h5c;

   typedef struct packed {
      logic [7:0] expected_leader;
      logic [1:0] expected_start;
      logic [5:0] expected_frame_mode;
      logic [3:0] toggle_value_a;
      logic [3:0] toggle_value_b;
      logic [7:0] expected_address;
   } cfg_type;

   typedef struct packed {
      logic [2:0] frame_status;
      logic [7:0] command_code;
      logic [2:0] key_class;
      logic       total_one_flag;
      logic       total_two_flag;
      logic       numeric_flag;
      logic       menu_flag;
      logic       key_event;
   } result_type;

endpackage

@@ rtl/irsfd_if.sv @@
// Valid/ready channel interfaces of the sampled IR frame decoder: request, response and CSR.
// Depends on irsfd_pkg for the CSR widths.
`timescale 1ns / 1ps
interface irsfd_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic pin_level;
   modport source (output valid, output mode, output pin_level, input ready);
   modport sink (input valid, input mode, input pin_level, output ready);
endinterface

interface irsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] frame_status;
   logic [7:0] command_code;
   logic [2:0] key_class;
   logic       total_one_flag;
   logic       total_two_flag;
   logic       numeric_flag;
   logic       menu_flag;
   logic       key_event;
   modport source (output valid, output frame_status, output command_code, output key_class,
                   output total_one_flag, output total_two_flag, output numeric_flag,
                   output menu_flag, output key_event, input ready);
   modport sink (input valid, input frame_status, input command_code, input key_class,
                 input total_one_flag, input total_two_flag, input numeric_flag,
                 input menu_flag, input key_event, output ready);
endinterface

interface irsfd_csr_if import irsfd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/irsfd_cell.sv @@
// One sample cell of the frame shift chain: a single stored pin level.
// Standalone; instantiated as a row by the top level.
`timescale 1ns / 1ps
module irsfd_cell (
   input  logic clock,
   input  logic shift_en,
   input  logic sample_in,
   output logic sample_out
);

   logic sample_ff;
   logic sample_in_mux;

   assign sample_in_mux = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_mux;
   end

   assign sample_out = sample_ff;

endmodule

@@ rtl/irsfd_decode.sv @@
// Frame field decode, checks, repeat detection and sticky key flags.
// Depends on irsfd_pkg; reads the first cells of the sample chain.
`timescale 1ns / 1ps
module irsfd_decode import irsfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      done,
   input  logic [DECODE_SAMPLES-1:0] samples,
   input  cfg_type                   cfg,
   output result_type                result
);

   logic [3:0] last_toggle_ff, last_toggle_in;
   logic [3:0] key_flags_ff, key_flags_in;
   logic [7:0] leader, address, command;
   logic [1:0] start;
   logic [5:0] frame_mode;
   logic [3:0] toggle;
   logic [3:0] flags_next;
   logic [2:0] status;
   logic [2:0] klass;

   // Sample 0 is the most significant bit of the leader; fields follow MSB first.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         leader[7-i]  = samples[i];
         address[7-i] = samples[21 + 2*i];
         command[7-i] = samples[37 + 2*i];
      end
      for (int i = 0; i < 2; i++) start[1-i] = samples[8 + i];
      for (int i = 0; i < 6; i++) frame_mode[5-i] = samples[10 + i];
      for (int i = 0; i < 4; i++) toggle[3-i] = samples[16 + i];
   end

   always_comb begin
      priority if (leader != cfg.expected_leader) begin
         status = STATUS_BAD_LEADER;
      end else if (start != cfg.expected_start) begin
         status = STATUS_BAD_START;
      end else if (frame_mode != cfg.expected_frame_mode) begin
         status = STATUS_BAD_MODE;
      end else if (toggle != cfg.toggle_value_a && toggle != cfg.toggle_value_b) begin
         status = STATUS_BAD_TOGGLE;
      end else if (address != cfg.expected_address) begin
         status = STATUS_BAD_ADDRESS;
      end else if (toggle == last_toggle_ff) begin
         status = STATUS_REPEAT;
      end else begin
         status = STATUS_NEW_KEY;
      end
   end

   // Flag bits: 0 total one, 1 total two, 2 numeric, 3 menu.
   always_comb begin
      klass      = CLASS_OTHER;
      flags_next = key_flags_ff;
      if (status == STATUS_NEW_KEY) begin
         priority if (command <= CMD_DIGIT_MAX) begin
            klass      = CLASS_DIGIT;
            flags_next = key_flags_ff | 4'b0100;
         end else if (command == CMD_TOTAL_ONE) begin
            klass      = CLASS_TOTAL_ONE;
            flags_next = {key_flags_ff[3], 3'b001};
         end else if (command == CMD_TOTAL_TWO) begin
            klass      = CLASS_TOTAL_TWO;
            flags_next = {key_flags_ff[3], 3'b010};
         end else if (command == CMD_MENU) begin
            klass      = CLASS_MENU;
            flags_next = {1'b1, 1'b0, key_flags_ff[1:0]};
         end else if (command == CMD_CLEAR_TOTALS) begin
            klass      = CLASS_CLEAR_TOTALS;
            flags_next = {key_flags_ff[3:2], 2'b00};
         end else begin
            klass      = CLASS_OTHER;
         end
      end
   end

   assign key_flags_in   = done ? flags_next : key_flags_ff;
   assign last_toggle_in = (done && status == STATUS_NEW_KEY) ? toggle : last_toggle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_toggle_ff <= '0;
         key_flags_ff   <= '0;
      end else begin
         last_toggle_ff <= last_toggle_in;
         key_flags_ff   <= key_flags_in;
      end
   end

   always_comb begin
      result.frame_status   = status;
      result.command_code   = (status == STATUS_NEW_KEY) ? command : 8'h00;
      result.key_class      = klass;
      result.total_one_flag = flags_next[0];
      result.total_two_flag = flags_next[1];
      result.numeric_flag   = flags_next[2];
      result.menu_flag      = flags_next[3];
      result.key_event      = (status == STATUS_NEW_KEY);
   end

endmodule

@@ rtl/ir_sampled_frame_decoder_core.sv @@
// Top level of the sampled IR frame decoder: control, CSRs, sample chain, response register.
// Depends on irsfd_pkg, irsfd_if, irsfd_cell and irsfd_decode.
`timescale 1ns / 1ps
// Usage:
// The request channel carries mode and pin_level. A request with mode 0 arms the
// decoder (the receiver edge); a request with mode 1 is a sample tick, stored only
// while armed. Ticks shift into a row of FRAME_SAMPLES one-bit cells, one cell
// per tick. The tick that completes a frame disarms the decoder; the frame is then
// decoded from the chain in the next cycle, while done_ff is set, and the result
// goes into the response register. Only a completing tick produces a response.
// Throughput is one request per cycle while request ready is high. Ready drops
// only while the last tick of a frame is due and the previous response is still
// pending, so a stalled response receiver holds off at most that one tick.
// The CSR channel is always ready; registers are written by index and must only
// change while the decoder is idle.
// Synchronous reset clears the CSRs, the arm state, the sample count, the last
// toggle and the key flags; sample cells are not cleared, since every decoded
// position is rewritten before each decode.
module ir_sampled_frame_decoder_core import irsfd_pkg::*; #(
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   irsfd_req_if.sink  req_if,
   irsfd_rsp_if.source rsp_if,
   irsfd_csr_if.sink  csr_if
);

   localparam int CNT_W = $clog2(FRAME_SAMPLES);

   cfg_type            cfg_ff, cfg_in;
   logic               armed_ff, armed_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;
   result_type         decode_result;
   logic [FRAME_SAMPLES-1:0] samples;
   logic               req_fire, tick_fire, last_slot;

   assign last_slot = (count_ff == CNT_W'(FRAME_SAMPLES - 1));
   assign req_if.ready = !(armed_ff && last_slot && (done_ff || rsp_valid_ff));
   assign req_fire  = req_if.valid && req_if.ready;
   assign tick_fire = req_fire && req_if.mode && armed_ff;

   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      if (req_fire && !req_if.mode) begin
         armed_in = 1'b1;
      end else if (tick_fire) begin
         if (last_slot) begin
            armed_in = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign done_in = tick_fire && last_slot;

   // New samples enter at the far end and move toward cell zero.
   genvar g;
   generate
      for (g = 0; g < FRAME_SAMPLES; g++) begin : g_cell
         logic cell_in;
         if (g == FRAME_SAMPLES - 1) begin : g_tail
            assign cell_in = req_if.pin_level;
         end else begin : g_body
            assign cell_in = samples[g+1];
         end
         irsfd_cell u_cell (
            .clock      (clock),
            .shift_en   (tick_fire),
            .sample_in  (cell_in),
            .sample_out (samples[g])
         );
      end
   endgenerate

   irsfd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .done    (done_ff),
      .samples (samples[DECODE_SAMPLES-1:0]),
      .cfg     (cfg_ff),
      .result  (decode_result)
   );

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_EXPECTED_LEADER:     cfg_in.expected_leader     = csr_if.data;
            CSR_EXPECTED_START:      cfg_in.expected_start      = csr_if.data[1:0];
            CSR_EXPECTED_FRAME_MODE: cfg_in.expected_frame_mode = csr_if.data[5:0];
            CSR_TOGGLE_VALUE_A:      cfg_in.toggle_value_a      = csr_if.data[3:0];
            CSR_TOGGLE_VALUE_B:      cfg_in.toggle_value_b      = csr_if.data[3:0];
            CSR_EXPECTED_ADDRESS:    cfg_in.expected_address    = csr_if.data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   assign rsp_valid_in = done_ff || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_data_in  = done_ff ? decode_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         armed_ff     <= armed_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.frame_status   = rsp_data_ff.frame_status;
   assign rsp_if.command_code   = rsp_data_ff.command_code;
   assign rsp_if.key_class      = rsp_data_ff.key_class;
   assign rsp_if.total_one_flag = rsp_data_ff.total_one_flag;
   assign rsp_if.total_two_flag = rsp_data_ff.total_two_flag;
   assign rsp_if.numeric_flag   = rsp_data_ff.numeric_flag;
   assign rsp_if.menu_flag      = rsp_data_ff.menu_flag;
   assign rsp_if.key_event      = rsp_data_ff.key_event;

   // A decode never lands on a response that is still waiting.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !rsp_valid_ff)
      else $error("decode while response register is occupied");

   // Samples are only counted while armed.
   assert property (@(posedge clock) disable iff (reset) (count_ff != '0) |-> armed_ff)
      else $error("sample count nonzero while disarmed");

   // The decode cycle follows a completed frame, so the sampler is idle.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!armed_ff && count_ff == '0))
      else $error("decode while sampling is active");

   // Every decode is presented on the response channel in the next cycle.
   assert property (@(posedge clock) disable iff (reset) done_ff |=> rsp_valid_ff)
      else $error("decoded frame did not reach the response register");

endmodule
